// File: rtl/sdq_pkg.sv
// sdq_pkg: shared types, constants and arithmetic for the stereo dither quantizer
// used by sdq_ctrl, sdq_dp and stereo_dither_quantizer; no dependencies
package sdq_pkg;

  localparam int SAMPLE_W = 40;
  localparam int SEED_W   = 31;
  localparam int DITH_W   = 16;
  localparam int PCM_W    = 16;
  localparam int PADDR_W  = 3;

  localparam logic [SEED_W-1:0] SEED_RESET = 31'h16BA2118;
  localparam logic [SEED_W-1:0] LCG_MUL    = 31'd1103515245;
  localparam logic [SEED_W-1:0] LCG_INC    = 31'd12345;

  // register word index
  localparam logic REG_DITHER_EN = 1'b0;

  // offset-binary bounds on the rounded integer part
  localparam logic [25:0] Q_LOW  = 26'h7F8000;
  localparam logic [25:0] Q_HIGH = 26'h807FFF;
  localparam logic [PCM_W-1:0] PCM_MIN = 16'h8000;
  localparam logic [PCM_W-1:0] PCM_MAX = 16'h7FFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP_L,
    ST_QUANT
  } state_t;

  typedef struct packed {
    logic load_in;
    logic step_r;
    logic step_l;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic dither_en;
  } status_t;

  function automatic logic [SEED_W-1:0] lcg_next(input logic [SEED_W-1:0] seed);
    logic [SEED_W-1:0] prod;
    prod = seed * LCG_MUL;
    return prod + LCG_INC;
  endfunction

  function automatic logic [PCM_W-1:0] quantize(input logic [SAMPLE_W-1:0] sample,
                                                 input logic [DITH_W-1:0] dith);
    logic [SAMPLE_W:0] u;
    logic [25:0]       q;
    logic [15:0]       frac;
    logic              rnd;
    logic [PCM_W-1:0]  res;
    u    = {1'b0, sample[SAMPLE_W-1] ^ 1'b1, sample[SAMPLE_W-2:0]}
           + {{(SAMPLE_W+1-DITH_W){1'b0}}, dith};
    frac = u[15:0];
    rnd  = (frac > 16'h8000) || ((frac == 16'h8000) && u[16]);
    q    = {1'b0, u[SAMPLE_W:16]} + {25'b0, rnd};
    if (q < Q_LOW) begin
      res = PCM_MIN;
    end else if (q > Q_HIGH) begin
      res = PCM_MAX;
    end else begin
      res = q[PCM_W-1:0];
    end
    return res;
  endfunction

endpackage

// File: rtl/stereo_dither_quantizer.sv
// stereo_dither_quantizer: top level joining controller and datapath
// depends on sdq_pkg, sdq_ctrl and sdq_dp
//
// Quantizes one stereo frame of 40-bit samples with 16 fraction bits to two
// signed 16-bit words (right in bits 31:16, left in 15:0), rounding to nearest
// with ties to even and saturating. With dither_enable set (register at byte
// address 0), a 31-bit LCG steps once for right and once for left and its top
// 16 bits are added to each sample first. Works on one frame at a time: with
// dither a frame goes through the transfer with the right generator step, the
// left generator step on the single multiplier, then rounding into the
// output register; without dither the transfer is followed directly by
// rounding into the output register. A new frame is taken while the previous
// result waits in the output register, but its rounding stalls until that
// result is taken.
module stereo_dither_quantizer
  import sdq_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [PADDR_W-1:0]         paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] left_sample,
  input  logic signed [SAMPLE_W-1:0] right_sample,
  input  logic                       last_frame,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [2*PCM_W-1:0]         packed_frame,
  output logic                       frame_end
);

  cmd_t    cmd;
  status_t status;

  assign pready = 1'b1;

  sdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  sdq_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .left_sample  (left_sample),
    .right_sample (right_sample),
    .last_frame   (last_frame),
    .packed_frame (packed_frame),
    .frame_end    (frame_end),
    .cmd          (cmd),
    .status       (status)
  );

endmodule

// File: rtl/sdq_ctrl.sv
// sdq_ctrl: sequencing state machine and output valid flag
// depends on sdq_pkg; drives sdq_dp through cmd_t
module sdq_ctrl
  import sdq_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = status.dither_en ? ST_STEP_L : ST_QUANT;
        end
      end
      ST_STEP_L: state_next = ST_QUANT;
      ST_QUANT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd.load_in  = 1'b0;
    cmd.step_r   = 1'b0;
    cmd.step_l   = 1'b0;
    cmd.load_out = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
        cmd.step_r  = in_valid && status.dither_en;
      end
      ST_STEP_L: cmd.step_l = 1'b1;
      ST_QUANT:  cmd.load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  a_load_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result loaded over an untaken result");

  a_dither_path: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && status.dither_en) |=> (state == ST_STEP_L))
    else $error("dithered transfer skipped the left generator step");

  a_plain_path: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !status.dither_en) |=> (state == ST_QUANT))
    else $error("plain transfer did not go straight to quantize");

endmodule

// File: rtl/sdq_dp.sv
// sdq_dp: config register, generator, sample holding, rounding and output register
// depends on sdq_pkg; controlled by sdq_ctrl through cmd_t
module sdq_dp
  import sdq_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [PADDR_W-1:0]         paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  input  logic signed [SAMPLE_W-1:0] left_sample,
  input  logic signed [SAMPLE_W-1:0] right_sample,
  input  logic                       last_frame,
  output logic [2*PCM_W-1:0]         packed_frame,
  output logic                       frame_end,
  input  cmd_t                       cmd,
  output status_t                    status
);

  logic                dither_en;
  logic [SEED_W-1:0]   seed;
  logic [SEED_W-1:0]   seed_next;
  logic [SAMPLE_W-1:0] left;
  logic [SAMPLE_W-1:0] right;
  logic                last;
  logic [DITH_W-1:0]   dith_r;
  logic [DITH_W-1:0]   dith_l;
  logic                step;

  assign status.dither_en = dither_en;
  assign step = cmd.step_r || cmd.step_l;

  always_ff @(posedge clk) begin
    if (rst) begin
      dither_en <= 1'b0;
    end else if (psel && penable && pwrite && paddr[2] == REG_DITHER_EN) begin
      dither_en <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == REG_DITHER_EN) ? {31'b0, dither_en} : 32'b0;

  assign seed_next = lcg_next(seed);

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= SEED_RESET;
    end else if (step) begin
      seed <= seed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      left  <= left_sample;
      right <= right_sample;
      last  <= last_frame;
    end
    if (cmd.step_r) begin
      dith_r <= seed_next[SEED_W-1 -: DITH_W];
    end else if (cmd.load_in) begin
      dith_r <= '0;
    end
    if (cmd.step_l) begin
      dith_l <= seed_next[SEED_W-1 -: DITH_W];
    end else if (cmd.load_in) begin
      dith_l <= '0;
    end
    if (cmd.load_out) begin
      packed_frame <= {quantize(right, dith_r), quantize(left, dith_l)};
      frame_end    <= last;
    end
  end

  a_seed_hold: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(seed))
    else $error("generator moved without a step");

endmodule

// File: tb/sdq_pcm_checker.sv
`timescale 1ns / 100ps
// sdq_pcm_checker: watches the register and frame ports of stereo_dither_quantizer,
// predicts every packed PCM result and compares it with what the block sends
// depends on sdq_pkg for port widths and the register index
module sdq_pcm_checker
  import sdq_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [31:0]         pwdata,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [SAMPLE_W-1:0] left_sample,
  input  logic [SAMPLE_W-1:0] right_sample,
  input  logic                last_frame,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [2*PCM_W-1:0]  packed_frame,
  input  logic                frame_end,
  output int                  errors,
  output int                  pending
);

  localparam logic [30:0] NOISE_SEED_INIT = 31'h16BA2118;
  localparam logic [63:0] NOISE_MUL       = 64'd1103515245;
  localparam logic [63:0] NOISE_INC       = 64'd12345;
  localparam logic [25:0] BIASED_PCM_MIN  = 26'h7F8000;
  localparam logic [25:0] BIASED_PCM_MAX  = 26'h807FFF;
  localparam logic [15:0] HALF_LSB        = 16'h8000;
  localparam logic [15:0] PCM_NEG_LIMIT   = 16'h8000;
  localparam logic [15:0] PCM_POS_LIMIT   = 16'h7FFF;

  typedef struct packed {
    logic [31:0] pcm;
    logic        last;
  } pcm_frame_t;

  pcm_frame_t  expected_frames[$];
  logic [30:0] noise_seed;
  logic        dither_on;

  initial begin
    errors  = 0;
    pending = 0;
  end

  function automatic logic [30:0] advance_noise(input logic [30:0] seed);
    logic [63:0] prod;
    prod = {33'b0, seed} * NOISE_MUL + NOISE_INC;
    return prod[30:0];
  endfunction

  // offset binary keeps the biased sum non-negative
  function automatic logic [15:0] round_to_pcm(input logic [39:0] sample,
                                               input logic [15:0] dith);
    logic [40:0] biased;
    logic [25:0] whole;
    logic [15:0] frac;
    biased = {1'b0, ~sample[39], sample[38:0]} + {25'b0, dith};
    whole  = {1'b0, biased[40:16]};
    frac   = biased[15:0];
    if (frac > HALF_LSB || (frac == HALF_LSB && whole[0])) begin
      whole = whole + 26'd1;
    end
    if (whole < BIASED_PCM_MIN) begin
      return PCM_NEG_LIMIT;
    end else if (whole > BIASED_PCM_MAX) begin
      return PCM_POS_LIMIT;
    end
    return whole[15:0];
  endfunction

  always @(posedge clk) begin
    pcm_frame_t  want;
    logic [15:0] dith_r;
    logic [15:0] dith_l;
    if (rst) begin
      noise_seed = NOISE_SEED_INIT;
      dither_on  = 1'b0;
      expected_frames.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_frames.size() == 0) begin
          if (errors < 10) begin
            $display("unexpected result: packed_frame %h frame_end %b", packed_frame, frame_end);
          end
          errors++;
        end else begin
          want = expected_frames.pop_front();
          if (packed_frame !== want.pcm || frame_end !== want.last) begin
            if (errors < 10) begin
              $display("mismatch: expected packed_frame %h frame_end %b, got %h %b",
                       want.pcm, want.last, packed_frame, frame_end);
            end
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        dith_r = '0;
        dith_l = '0;
        // right channel draws first
        if (dither_on) begin
          noise_seed = advance_noise(noise_seed);
          dith_r     = noise_seed[30:15];
          noise_seed = advance_noise(noise_seed);
          dith_l     = noise_seed[30:15];
        end
        want.pcm  = {round_to_pcm(right_sample, dith_r), round_to_pcm(left_sample, dith_l)};
        want.last = last_frame;
        expected_frames.push_back(want);
      end
      if (psel && penable && pwrite && pready && paddr[2] == REG_DITHER_EN) begin
        dither_on = pwdata[0];
      end
    end
    pending = expected_frames.size();
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// tb: stimulus and verdict for stereo_dither_quantizer; drives frames and register
// writes under changing idle patterns, checking is done by sdq_pcm_checker
// depends on sdq_pkg, sdq_pcm_checker and the block itself
module tb;
  import sdq_pkg::*;

  localparam int CYCLE_LIMIT      = 400000;
  localparam int HALF_PHASE_ITEMS = 158;
  localparam int SEND_IDLE_PCT [3] = '{34, 65, 0};
  localparam int RECV_IDLE_PCT [3] = '{65, 34, 0};
  localparam logic [PADDR_W-1:0] DITHER_ADDR   = PADDR_W'({REG_DITHER_EN, 2'b00});
  localparam logic [PADDR_W-1:0] UNMAPPED_ADDR = PADDR_W'(4);
  localparam logic [SAMPLE_W-1:0] CORNER_SAMPLES [12] = '{
    40'h0000000000, 40'h7FFFFFFFFF, 40'h8000000000, 40'h0000008000,
    40'h0000018000, 40'hFFFFFF8000, 40'hFFFFFE8000, 40'h007FFF8000,
    40'h007FFF7FFF, 40'hFF7FFF8000, 40'hFF7FFF0000, 40'h0000008001
  };

  logic                       clk;
  logic                       rst;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [PADDR_W-1:0]         paddr;
  logic [31:0]                pwdata;
  logic [31:0]                prdata;
  logic                       pready;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] left_sample;
  logic signed [SAMPLE_W-1:0] right_sample;
  logic                       last_frame;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [2*PCM_W-1:0]         packed_frame;
  logic                       frame_end;
  int                         check_errors;
  int                         frames_pending;
  int                         send_idle;
  int                         recv_idle;
  int                         cycle_count;

  stereo_dither_quantizer dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .left_sample  (left_sample),
    .right_sample (right_sample),
    .last_frame   (last_frame),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .packed_frame (packed_frame),
    .frame_end    (frame_end)
  );

  sdq_pcm_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .left_sample  (left_sample),
    .right_sample (right_sample),
    .last_frame   (last_frame),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .packed_frame (packed_frame),
    .frame_end    (frame_end),
    .errors       (check_errors),
    .pending      (frames_pending)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    longint v;
    case ($urandom_range(0, 3))
      0: v = {$urandom(), $urandom()};
      1: v = longint'($signed($urandom()));
      2: v = ($urandom_range(0, 1) ? 64'sd32767 : -64'sd32768) * 65536
             + $urandom_range(0, 131071) - 65536;
      default: v = longint'($signed(16'($urandom()))) * 65536 + 32768;
    endcase
    return v[SAMPLE_W-1:0];
  endfunction

  task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_frame(input logic [SAMPLE_W-1:0] l, input logic [SAMPLE_W-1:0] r,
                            input logic lf);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    left_sample  <= l;
    right_sample <= r;
    last_frame   <= lf;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_frames();
    @(negedge clk);
    in_valid <= 1'b0;
    while (frames_pending != 0) @(negedge clk);
  endtask

  initial begin
    logic [31:0] data;
    rst          = 1'b1;
    cycle_count  = 0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_valid     = 1'b0;
    left_sample  = '0;
    right_sample = '0;
    last_frame   = 1'b0;
    send_idle    = SEND_IDLE_PCT[0];
    recv_idle    = RECV_IDLE_PCT[0];
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // write outside the register map must leave dither off
    reg_write(UNMAPPED_ADDR, 32'hFFFF_FFFF);
    for (int i = 0; i < 12; i++) begin
      send_frame(CORNER_SAMPLES[i], CORNER_SAMPLES[11-i], i[0]);
    end
    drain_frames();
    reg_write(DITHER_ADDR, 32'h0000_0001);
    for (int i = 0; i < 12; i++) begin
      send_frame(CORNER_SAMPLES[11-i], CORNER_SAMPLES[i], ~i[0]);
    end

    for (int p = 0; p < 3; p++) begin
      send_idle = SEND_IDLE_PCT[p];
      recv_idle = RECV_IDLE_PCT[p];
      for (int h = 0; h < 2; h++) begin
        drain_frames();
        data    = $urandom();
        data[0] = ((p + h) % 2 == 0);
        reg_write(DITHER_ADDR, data);
        for (int n = 0; n < HALF_PHASE_ITEMS; n++) begin
          if ($urandom_range(0, 99) == 0) begin
            drain_frames();
          end
          send_frame(pick_sample(), pick_sample(), $urandom_range(0, 7) == 0);
        end
      end
    end

    drain_frames();
    repeat (20) @(posedge clk);
    if (check_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/sdq_pkg.sv
rtl/sdq_ctrl.sv
rtl/sdq_dp.sv
rtl/stereo_dither_quantizer.sv
tb/sdq_pcm_checker.sv
tb/tb.sv
